/* rtl/rkpc_pkg.sv */
// ----------------------------------------------------------------------------
// rkpc_pkg
// Shared constants, types and the static key table of the rolling key cipher.
// ----------------------------------------------------------------------------
package rkpc_pkg;

  localparam int LEN_BITS  = 16;
  localparam int HDR_BYTES = 5;

  localparam logic [7:0]  HDR_CODE = 8'h57;
  localparam logic [31:0] KEY_HIGH = 32'h87546ca1;

  // first character sits in the top byte
  localparam logic [511:0] STATIC_KEY =
    "nKO/WctQ0AVLbpzfBkS6NevDYT8ourG5CRlmdjyJ72aswx4EPq1UgZhFMXH?3iI9";

  typedef logic [LEN_BITS-1:0] pos_t;

  typedef enum logic [0:0] {
    REQ_DECRYPT = 1'b0,
    REQ_ENCRYPT = 1'b1
  } req_t;

  typedef struct packed {
    logic [7:0] dout;
    logic [7:0] plain;
    logic [7:0] cipher;
  } xform_t;

  // character idx of the static key: byte (63 - idx) from the bottom
  function automatic logic [7:0] static_key_byte(input logic [5:0] idx);
    return STATIC_KEY[{~idx, 3'b000} +: 8];
  endfunction

endpackage

/* rtl/rkpc_if.sv */
// ----------------------------------------------------------------------------
// rkpc channel interfaces
// Valid/ready channels for input bytes and result bytes of the cipher.
// ----------------------------------------------------------------------------
interface rkpc_in_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, req_type, data_byte, last_byte, input ready);
  modport sink   (input valid, req_type, data_byte, last_byte, output ready);
endinterface

interface rkpc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       end_of_packet;
  logic       header_ok;

  modport source (output valid, out_byte, end_of_packet, header_ok, input ready);
  modport sink   (input valid, out_byte, end_of_packet, header_ok, output ready);
endinterface

/* rtl/rkpc_xform.sv */
// ----------------------------------------------------------------------------
// rkpc_xform
// Byte transform: if enabled, XOR of data with direction key byte, static key
// byte and the previous ciphertext byte; gives output, plaintext and ciphertext.
// ----------------------------------------------------------------------------
module rkpc_xform (
  input  logic                 enabled,
  input  logic                 req_type,
  input  logic [7:0]           din,
  input  logic [63:0]          key,
  input  rkpc_pkg::pos_t       pos,
  input  logic [7:0]           chain,
  output rkpc_pkg::xform_t     res
);

  logic [7:0] key_b;
  logic [7:0] mix;
  logic [7:0] dout;
  logic       enc;

  assign enc   = (req_type == rkpc_pkg::REQ_ENCRYPT);
  assign key_b = key[{pos[2:0], 3'b000} +: 8];

  // first byte of a packet uses the direction key alone
  assign mix  = (pos == '0) ? key_b
              : (key_b ^ rkpc_pkg::static_key_byte(pos[5:0]) ^ chain);
  assign dout = enabled ? (din ^ mix) : din;

  always_comb begin
    res.dout = dout;
    if (enc) begin
      res.plain  = din;
      res.cipher = dout;
    end else begin
      res.plain  = dout;
      res.cipher = din;
    end
  end

endmodule

/* rtl/rolling_key_packet_cipher.sv */
// ----------------------------------------------------------------------------
// rolling_key_packet_cipher
// Rolling key packet byte cipher for both directions with header check.
// ----------------------------------------------------------------------------
// One byte is accepted per clock and its result appears in the output
// register on the next cycle; the input stays ready while the output
// register is empty or being taken, so throughput is one beat per cycle.
// All work for a byte (key byte select, XOR chain, header compare and the
// 64-bit key add at packet end) sits between the state registers and the
// output register. Writing cfg_base_key reloads both direction keys and
// disables the cipher; write only while no beat is in flight.
module rolling_key_packet_cipher (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [31:0]        cfg_base_key,
  rkpc_in_if.sink            in_ch,
  rkpc_out_if.source         out_ch
);

  logic                  accept;
  logic                  enc;
  logic                  last;
  logic [63:0]           key_sel;
  rkpc_pkg::xform_t      xf;
  rkpc_pkg::pos_t        len;
  logic [7:0]            hb [rkpc_pkg::HDR_BYTES];
  logic                  hdr_ok;
  logic                  ok;

  logic [63:0]           client_key_r, client_key_nxt;
  logic [63:0]           server_key_r, server_key_nxt;
  logic [7:0]            chain_r, chain_nxt;
  rkpc_pkg::pos_t        pos_r, pos_nxt;
  logic                  enabled_r, enabled_nxt;
  logic [7:0]            hdr_r [rkpc_pkg::HDR_BYTES];

  logic                  out_valid_r;
  logic [7:0]            out_byte_r;
  logic                  out_eop_r;
  logic                  out_ok_r;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign enc         = (in_ch.req_type == rkpc_pkg::REQ_ENCRYPT);
  assign last        = in_ch.last_byte;
  assign key_sel     = enc ? server_key_r : client_key_r;
  assign len         = pos_r + rkpc_pkg::pos_t'(1);

  rkpc_xform u_xform (
    .enabled  (enabled_r),
    .req_type (in_ch.req_type),
    .din      (in_ch.data_byte),
    .key      (key_sel),
    .pos      (pos_r),
    .chain    (chain_r),
    .res      (xf)
  );

  // header bytes as seen after this beat's capture
  always_comb begin
    for (int i = 0; i < rkpc_pkg::HDR_BYTES; i++) begin
      hb[i] = (pos_r == rkpc_pkg::pos_t'(i)) ? xf.plain : hdr_r[i];
    end
  end

  assign hdr_ok = (len >= rkpc_pkg::pos_t'(rkpc_pkg::HDR_BYTES))
               && ({hb[1], hb[0]} == ~{hb[4], hb[3]})
               && (hb[2] == rkpc_pkg::HDR_CODE);

  assign ok = !(last && enabled_r && !enc) || hdr_ok;

  always_comb begin
    client_key_nxt = client_key_r;
    server_key_nxt = server_key_r;
    chain_nxt      = chain_r;
    pos_nxt        = pos_r;
    enabled_nxt    = enabled_r;
    if (cfg_wr_en) begin
      client_key_nxt = {rkpc_pkg::KEY_HIGH, cfg_base_key};
      server_key_nxt = {rkpc_pkg::KEY_HIGH, cfg_base_key};
      enabled_nxt    = 1'b0;
    end else if (accept) begin
      chain_nxt = xf.cipher;
      pos_nxt   = last ? '0 : len;
      if (last) begin
        if (!enabled_r) begin
          if (enc) begin
            enabled_nxt = 1'b1;
          end
        end else if (enc) begin
          server_key_nxt = server_key_r + {{(64 - rkpc_pkg::LEN_BITS){1'b0}}, len};
        end else if (hdr_ok) begin
          client_key_nxt = client_key_r + {{(64 - rkpc_pkg::LEN_BITS){1'b0}}, len};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      client_key_r <= {rkpc_pkg::KEY_HIGH, 32'h0};
      server_key_r <= {rkpc_pkg::KEY_HIGH, 32'h0};
      chain_r      <= '0;
      pos_r        <= '0;
      enabled_r    <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      client_key_r <= client_key_nxt;
      server_key_r <= server_key_nxt;
      chain_r      <= chain_nxt;
      pos_r        <= pos_nxt;
      enabled_r    <= enabled_nxt;
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // header capture and result payload, no reset needed
  always_ff @(posedge clk) begin
    for (int i = 0; i < rkpc_pkg::HDR_BYTES; i++) begin
      if (accept && (pos_r == rkpc_pkg::pos_t'(i))) begin
        hdr_r[i] <= xf.plain;
      end
    end
    if (accept) begin
      out_byte_r <= xf.dout;
      out_eop_r  <= last;
      out_ok_r   <= ok;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.out_byte      = out_byte_r;
  assign out_ch.end_of_packet = out_eop_r;
  assign out_ch.header_ok     = out_ok_r;

  // a key write always leaves the cipher bypassed
  a_cfg_disables: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr_en |=> !enabled_r)
    else $error("cipher still enabled after key write");

  a_pos_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && last && !cfg_wr_en) |=> (pos_r == '0))
    else $error("position not cleared after last beat");

  a_bypass_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !enabled_r) |=> (out_byte_r == $past(in_ch.data_byte)))
    else $error("bypassed beat altered");

  a_ok_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ok_r) |-> out_eop_r)
    else $error("header failure flagged on non-final beat");

  a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid_r)
    else $error("accepted beat did not reach output register");

endmodule
